### design/tilt_estimator_state_feedback_macros.svh
// Assertion macros for the tilt estimator.
`ifndef TILT_ESTIMATOR_STATE_FEEDBACK_MACROS_SVH
`define TILT_ESTIMATOR_STATE_FEEDBACK_MACROS_SVH

// same-cycle implication, reset masked
`define TESF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define TESF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tesf_pkg.sv
// Constants, tables and defaults shared by the tilt estimator.
`default_nettype none
package tesf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CNT_W            = 5;

    localparam logic signed [32:0] RATE_K_Q32 = 33'sd572224;
    localparam logic signed [34:0] PI_Q30     = 35'sd3373259426;
    localparam logic signed [32:0] ONE_Q16    = 33'sd65536;

    // half of the 1e6 * 65536 divisor, added before the division
    localparam logic [53:0] DIV_HALF = 54'd32768000000;

    // 1e6 * 65536 = 2^22 * 15625; (x * INC_RECIP) >> INC_SHIFT is x / 15625
    // for every x below 2^30
    localparam logic signed [32:0] INC_RECIP = 33'sd1125899907;
    localparam int                 INC_SHIFT = 44;

    localparam logic [2:0] REG_GAIN_PITCH  = 3'd0;
    localparam logic [2:0] REG_GAIN_RATE   = 3'd1;
    localparam logic [2:0] REG_GAIN_WANGLE = 3'd2;
    localparam logic [2:0] REG_GAIN_WSPEED = 3'd3;
    localparam logic [2:0] REG_ALPHA       = 3'd4;
    localparam logic [2:0] REG_TRUST       = 3'd5;
    localparam logic [2:0] REG_OFFSET      = 3'd6;
    localparam logic [2:0] REG_LIMIT       = 3'd7;

    // atan(2^-i) in Q2.30
    function automatic logic signed [34:0] atan_q30(input logic [CNT_W-1:0] idx);
        logic signed [34:0] r;
        case (idx)
            5'd0:  r = 35'sd843314857;
            5'd1:  r = 35'sd497837829;
            5'd2:  r = 35'sd263043836;
            5'd3:  r = 35'sd133525158;
            5'd4:  r = 35'sd67021686;
            5'd5:  r = 35'sd33543515;
            5'd6:  r = 35'sd16775850;
            5'd7:  r = 35'sd8388437;
            5'd8:  r = 35'sd4194282;
            5'd9:  r = 35'sd2097149;
            5'd10: r = 35'sd1048575;
            5'd11: r = 35'sd524287;
            5'd12: r = 35'sd262143;
            5'd13: r = 35'sd131071;
            5'd14: r = 35'sd65535;
            5'd15: r = 35'sd32767;
            5'd16: r = 35'sd16383;
            5'd17: r = 35'sd8191;
            5'd18: r = 35'sd4095;
            5'd19: r = 35'sd2047;
            5'd20: r = 35'sd1023;
            5'd21: r = 35'sd511;
            5'd22: r = 35'sd255;
            5'd23: r = 35'sd127;
            default: r = 35'sd0;
        endcase
        return r;
    endfunction

    // saturate to a signed width of w bits
    function automatic logic signed [65:0] sat_w(input logic signed [65:0] v, input int w);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = (66'sd1 <<< (w - 1)) - 66'sd1;
        lo = -hi - 66'sd1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

endpackage
`default_nettype wire

### design/tilt_estimator_state_feedback.sv
// Tilt estimator with complementary filter and four-gain state-feedback drive.
//
// Usage:
//   s_ channel: one sensor request per control tick (accel X/Z, gyro Y,
//   elapsed microseconds, wheel angle and speed), sample_valid on s_tuser.
//   m_ channel: one result per request (drive, pitch, rate, accel tilt).
//   cfg port: gains, filter weights, offset and drive limit; write while idle.
// Timing:
//   A valid sample runs the rate, CORDIC, tilt, increment, filter and gain steps
//   before m_tvalid; an invalid sample skips the rate, CORDIC and tilt steps.
//   The CORDIC runs one rotation a cycle; the inverse-time division is a
//   multiply by a reciprocal. All products share one 33x33 multiplier
//   with a registered output.
//   s_tready is high only while the sequencer is idle: one request at a time,
//   the next one can be accepted in the cycle after the result is written.
// Reset (aresetn low, synchronous): registers return to defaults, filter
//   state clears to zero, no result pending.
// Stall: the result sits in an output register; s_tready comes back as soon
//   as it is written, and the next result waits in its last step until the
//   previous one is taken.
`default_nettype none
`include "tilt_estimator_state_feedback_macros.svh"
module tilt_estimator_state_feedback
    import tesf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // accel_x[15:0] accel_z[31:16] gyro_y[47:32] elapsed_us[63:48]
    // wheel_angle[95:64] wheel_speed[127:96]
    input  wire logic [127:0] s_tdata,
    // sample_valid[0]
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // drive[31:0] pitch_angle[52:32] pitch_rate[73:53] accel_angle[93:74] zero[95:94]
    output logic [95:0]       m_tdata,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE, S_RATE, S_RATE_W, S_CORDIC, S_TILT,
        S_INC_A, S_INC_B, S_INC_C, S_INC_D, S_DIV,
        S_FILT_A, S_FILT_B, S_FILT_C, S_FILT_D,
        S_G0, S_G1, S_G2, S_G3, S_G4
    } state_t;

    state_t state_reg;

    // configuration
    logic signed [31:0] gp_reg, gr_reg, gwa_reg, gws_reg;
    logic        [16:0] alpha_reg, trust_reg;
    logic signed [19:0] offset_reg;
    logic        [30:0] limit_reg;

    // filter state
    logic signed [23:0] pitch_reg;
    logic signed [20:0] rate_reg;
    logic signed [19:0] tilt_reg;

    // latched request
    logic signed [15:0] gy_reg;
    logic        [15:0] el_reg;
    logic signed [31:0] wa_reg, ws_reg;
    logic        [16:0] alpha_eff_reg, trust_eff_reg;

    // CORDIC
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [34:0] cz_reg;
    logic               czero_reg;
    logic [CNT_W-1:0]   cnt_reg;

    // shared multiplier and accumulator
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;
    logic signed [65:0] acc_reg;

    // increment path
    logic        [18:0] ahi_reg;
    logic               neg_reg;
    logic        [29:0] xq_reg;
    logic signed [24:0] p_reg;

    // request fields
    logic signed [15:0] in_ax, in_az;
    logic signed [16:0] ax_e, az_e;
    assign in_ax = s_tdata[15:0];
    assign in_az = s_tdata[31:16];
    assign ax_e  = 17'(in_ax);
    assign az_e  = 17'(in_az);

    assign s_tready = (state_reg == S_IDLE);

    // multiplier operand select
    logic signed [21:0] rate_mag;
    assign rate_mag = rate_reg[20] ? -22'(rate_reg) : 22'(rate_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_RATE:   begin mul_a = 33'(gy_reg);                    mul_b = RATE_K_Q32; end
            S_INC_A:  begin mul_a = 33'(rate_mag);                  mul_b = 33'(el_reg); end
            S_INC_B:  begin mul_a = 33'(prod_reg[17:0]);            mul_b = 33'(trust_eff_reg); end
            S_INC_C:  begin mul_a = 33'(ahi_reg);                   mul_b = 33'(trust_eff_reg); end
            S_DIV:    begin mul_a = 33'(xq_reg);                    mul_b = INC_RECIP; end
            S_FILT_B: begin mul_a = 33'(p_reg);                     mul_b = 33'(alpha_eff_reg); end
            S_FILT_C: begin mul_a = 33'(tilt_reg);
                            mul_b = ONE_Q16 - 33'(alpha_eff_reg); end
            S_G0:     begin mul_a = 33'(gp_reg);                    mul_b = 33'(pitch_reg); end
            S_G1:     begin mul_a = 33'(gr_reg);                    mul_b = 33'(rate_reg); end
            S_G2:     begin mul_a = 33'(gwa_reg);                   mul_b = 33'(wa_reg); end
            S_G3, S_G4: begin mul_a = 33'(gws_reg);                 mul_b = 33'(ws_reg); end
            default:  begin mul_a = '0;                             mul_b = '0; end
        endcase
    end

    // CORDIC rotation step
    logic signed [33:0] xs, ys;
    assign xs = cx_reg >>> cnt_reg;
    assign ys = cy_reg >>> cnt_reg;

    // datapath results used at state transitions
    logic signed [65:0] rate_rnd, rate_sat, tilt_rnd, tilt_sat;
    logic signed [65:0] filt_n, filt_q, filt_sat;
    logic signed [65:0] drv_s, drv_u, lim_s, drv_c, drv_n;
    logic signed [35:0] nz;
    logic signed [65:0] inc_s;
    logic        [53:0] inc_m;
    always_comb begin
        rate_rnd = (prod_reg + (66'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
        rate_sat = sat_w(rate_rnd, 21);
        nz       = -36'(cz_reg);
        tilt_rnd = 66'((nz + (36'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
        tilt_sat = sat_w(tilt_rnd, 20);
        filt_n   = acc_reg + prod_reg;
        if (filt_n >= 0) begin
            filt_q = (filt_n + 66'sd32768) >>> 16;
        end else begin
            filt_q = -((-filt_n + 66'sd32768) >>> 16);
        end
        filt_sat = sat_w(filt_q, 24);
        // |rate*el*trust| + half divisor
        inc_m    = 54'(acc_reg + (prod_reg <<< 18)) + DIV_HALF;
        inc_s    = neg_reg ? -66'(prod_reg[INC_SHIFT+17:INC_SHIFT])
                           : 66'(prod_reg[INC_SHIFT+17:INC_SHIFT]);
        drv_s    = acc_reg + (prod_reg >>> 2);
        drv_u    = (drv_s + (66'sd1 <<< (FRAC_BITS - 3))) >>> (FRAC_BITS - 2);
        lim_s    = 66'(limit_reg);
        if (drv_u > lim_s) begin
            drv_c = lim_s;
        end else if (drv_u < -lim_s) begin
            drv_c = -lim_s;
        end else begin
            drv_c = drv_u;
        end
        drv_n    = -drv_c;
    end

    logic signed [65:0] pa_sum, pa_sat;
    assign pa_sum = 66'(pitch_reg) + 66'(offset_reg);
    assign pa_sat = sat_w(pa_sum, 21);

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;

        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_tvalid  <= 1'b0;
            gp_reg    <= '0;
            gr_reg    <= '0;
            gwa_reg   <= '0;
            gws_reg   <= '0;
            alpha_reg <= 17'd64225;
            trust_reg <= 17'd65536;
            offset_reg <= '0;
            limit_reg <= 31'd655360;
            pitch_reg <= '0;
            rate_reg  <= '0;
            tilt_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_GAIN_PITCH:  gp_reg     <= cfg_wdata;
                    REG_GAIN_RATE:   gr_reg     <= cfg_wdata;
                    REG_GAIN_WANGLE: gwa_reg    <= cfg_wdata;
                    REG_GAIN_WSPEED: gws_reg    <= cfg_wdata;
                    REG_ALPHA:       alpha_reg  <= cfg_wdata[16:0];
                    REG_TRUST:       trust_reg  <= cfg_wdata[16:0];
                    REG_OFFSET:      offset_reg <= cfg_wdata[19:0];
                    REG_LIMIT:       limit_reg  <= cfg_wdata[30:0];
                    default: ;
                endcase
            end

            // the final step reloads the output itself
            if (m_tvalid && m_tready && state_reg != S_G4) begin
                m_tvalid <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        gy_reg <= s_tdata[47:32];
                        el_reg <= s_tdata[63:48];
                        wa_reg <= s_tdata[95:64];
                        ws_reg <= s_tdata[127:96];
                        alpha_eff_reg <= (alpha_reg > 17'd65536) ? 17'd65536 : alpha_reg;
                        trust_eff_reg <= (trust_reg > 17'd65536) ? 17'd65536 : trust_reg;
                        // pre-rotate into the right half plane: x = -az, y = ax
                        czero_reg <= (in_ax == 16'sd0) && (in_az == 16'sd0);
                        if (in_az > 16'sd0) begin
                            cx_reg <= 34'(az_e) <<< 15;
                            cy_reg <= 34'(-ax_e) <<< 15;
                            cz_reg <= (in_ax >= 16'sd0) ? PI_Q30 : -PI_Q30;
                        end else begin
                            cx_reg <= 34'(-az_e) <<< 15;
                            cy_reg <= 34'(ax_e) <<< 15;
                            cz_reg <= '0;
                        end
                        cnt_reg   <= '0;
                        state_reg <= s_tuser ? S_RATE : S_INC_A;
                    end
                end
                S_RATE: state_reg <= S_RATE_W;
                S_RATE_W: begin
                    rate_reg  <= rate_sat[20:0];
                    state_reg <= S_CORDIC;
                end
                S_CORDIC: begin
                    if (cy_reg >= 0) begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + atan_q30(cnt_reg);
                    end else begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - atan_q30(cnt_reg);
                    end
                    if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                        state_reg <= S_TILT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_TILT: begin
                    tilt_reg  <= czero_reg ? 20'sd0 : tilt_sat[19:0];
                    state_reg <= S_INC_A;
                end
                S_INC_A: begin
                    neg_reg   <= rate_reg[20];
                    state_reg <= S_INC_B;
                end
                S_INC_B: begin
                    ahi_reg   <= prod_reg[36:18];
                    state_reg <= S_INC_C;
                end
                S_INC_C: begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_INC_D;
                end
                S_INC_D: begin
                    // drop the 2^22 factor of the divisor, 15625 is left
                    xq_reg    <= inc_m[51:22];
                    state_reg <= S_DIV;
                end
                S_DIV: state_reg <= S_FILT_A;
                S_FILT_A: begin
                    p_reg     <= 25'(66'(pitch_reg) + inc_s);
                    state_reg <= S_FILT_B;
                end
                S_FILT_B: state_reg <= S_FILT_C;
                S_FILT_C: begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_FILT_D;
                end
                S_FILT_D: begin
                    pitch_reg <= filt_sat[23:0];
                    state_reg <= S_G0;
                end
                S_G0: state_reg <= S_G1;
                S_G1: begin
                    acc_reg   <= prod_reg >>> 2;
                    state_reg <= S_G2;
                end
                S_G2: begin
                    acc_reg   <= acc_reg + (prod_reg >>> 2);
                    state_reg <= S_G3;
                end
                S_G3: begin
                    acc_reg   <= acc_reg + (prod_reg >>> 2);
                    state_reg <= S_G4;
                end
                S_G4: begin
                    // hold here while a previous result is still pending
                    if (!m_tvalid || m_tready) begin
                        m_tdata   <= {2'b00, tilt_reg, rate_reg,
                                      pa_sat[20:0], drv_n[31:0]};
                        m_tvalid  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    logic signed [31:0] m_drive;
    logic signed [31:0] lim32;
    assign m_drive = m_tdata[31:0];
    assign lim32   = {1'b0, limit_reg};

    `TESF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "sequencer still ready after accepting a request")
    `TESF_ASSERT_NOW(a_result_from_last_step, $rose(m_tvalid),
        $past(state_reg == S_G4), "result raised outside the final step")
    `TESF_ASSERT_NOW(a_drive_bounded, m_tvalid,
        (m_drive <= lim32) && (m_drive >= -lim32), "drive outside the limit")

endmodule
`default_nettype wire

### dv/tb_tilt_estimator_state_feedback.sv
// Self-checking testbench for the tilt estimator with state-feedback drive.
`default_nettype none
module tb_tilt_estimator_state_feedback;
    import tesf_pkg::*;

    // one sensor request as the block sees it
    typedef struct {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_y;
        logic               sample_valid;
        logic        [15:0] elapsed_us;
        logic signed [31:0] wheel_angle;
        logic signed [31:0] wheel_speed;
    } sensor_req_t;

    // one result: drive command and the filter outputs
    typedef struct {
        logic signed [31:0] drive;
        logic signed [20:0] pitch_angle;
        logic signed [20:0] pitch_rate;
        logic signed [19:0] accel_angle;
    } control_out_t;

    localparam longint PI_Q30_L   = 64'sd3373259426;
    localparam longint ONE_Q16_L  = 64'sd65536;
    localparam longint INC_DIV    = 64'sd65536000000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic         cfg_wr_en;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_wdata;

    tilt_estimator_state_feedback uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // shadow copy of the register file
    longint k_pitch, k_rate, k_wangle, k_wspeed;
    longint alpha_reg, trust_reg, offset_reg, limit_reg;
    // shadow copy of the filter state
    longint pitch_est, rate_est, tilt_est;

    sensor_req_t  pending_reqs[$];
    control_out_t expected_outs[$];
    int  error_count;
    int  checked_count;
    int  invalid_count;
    bit  src_quiet;   // sender never idles while set
    bit  sink_quiet;  // receiver never stalls while set

    // ---------------- fixed-point helpers ----------------
    function automatic longint sat_s(longint v, int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // divide, rounding half away from zero
    function automatic longint div_round(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    // -atan2(y, x) by vectoring CORDIC, Q2.30 internally, Q.16 out
    function automatic longint cordic_neg_atan2(longint y, longint x);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            // pre-rotate by pi into the right half-plane
            z = (y >= 0) ? PI_Q30_L : -PI_Q30_L;
            x = -x;
            y = -y;
        end
        x = x * 32768;
        y = y * 32768;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + longint'(atan_q30(i[4:0]));
            end else begin
                x = x - ys; y = y + xs; z = z - longint'(atan_q30(i[4:0]));
            end
        end
        return (-z + (64'sd1 <<< 13)) >>> 14;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            REG_GAIN_PITCH:  k_pitch    = longint'($signed(v));
            REG_GAIN_RATE:   k_rate     = longint'($signed(v));
            REG_GAIN_WANGLE: k_wangle   = longint'($signed(v));
            REG_GAIN_WSPEED: k_wspeed   = longint'($signed(v));
            REG_ALPHA:       alpha_reg  = longint'(v[16:0]);
            REG_TRUST:       trust_reg  = longint'(v[16:0]);
            REG_OFFSET:      offset_reg = longint'($signed(v[19:0]));
            REG_LIMIT:       limit_reg  = longint'(v[30:0]);
            default: ;
        endcase
    endfunction

    // filter update plus drive law; advances the shadow state
    function automatic control_out_t step_filter(sensor_req_t r);
        control_out_t o;
        longint alpha;
        longint trust;
        longint inc;
        longint p;
        longint s;
        longint u;
        alpha = (alpha_reg > ONE_Q16_L) ? ONE_Q16_L : alpha_reg;
        trust = (trust_reg > ONE_Q16_L) ? ONE_Q16_L : trust_reg;
        if (r.sample_valid) begin
            // counts -> rad/s with pi/(180*131) in Q0.32, round half up
            rate_est = sat_s((longint'(r.gyro_y) * 572224 + (64'sd1 <<< 15)) >>> 16, 21);
            tilt_est = sat_s(cordic_neg_atan2(longint'(r.accel_x),
                                              -longint'(r.accel_z)), 20);
        end
        inc = div_round(rate_est * longint'(r.elapsed_us) * trust, INC_DIV);
        p = pitch_est + inc;
        pitch_est = sat_s(div_round(alpha * p + (ONE_Q16_L - alpha) * tilt_est,
                                    ONE_Q16_L), 24);
        s = ((k_pitch * pitch_est) >>> 2) + ((k_rate * rate_est) >>> 2)
          + ((k_wangle * longint'(r.wheel_angle)) >>> 2)
          + ((k_wspeed * longint'(r.wheel_speed)) >>> 2);
        u = (s + (64'sd1 <<< 13)) >>> 14;
        if (u > limit_reg) u = limit_reg;
        if (u < -limit_reg) u = -limit_reg;
        o.drive       = 32'(-u);
        o.pitch_angle = 21'(sat_s(pitch_est + offset_reg, 21));
        o.pitch_rate  = 21'(rate_est);
        o.accel_angle = 20'(tilt_est);
        return o;
    endfunction

    // ---------------- clock, reset, timeout ----------------
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("timeout at %0t", $time);
        $display("simulation failed");
        $finish;
    end

    // ---------------- request driver ----------------
    int src_gap;
    always @(posedge aclk) begin
        bit          nv;
        sensor_req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            src_gap  <= 0;
        end else begin
            nv = s_tvalid;
            if (s_tvalid && s_tready) begin
                // accepted: predict now, config is static during traffic
                r.accel_x      = s_tdata[15:0];
                r.accel_z      = s_tdata[31:16];
                r.gyro_y       = s_tdata[47:32];
                r.elapsed_us   = s_tdata[63:48];
                r.wheel_angle  = s_tdata[95:64];
                r.wheel_speed  = s_tdata[127:96];
                r.sample_valid = s_tuser;
                expected_outs.push_back(step_filter(r));
                if (!s_tuser) invalid_count++;
                nv = 1'b0;
                src_gap <= src_quiet ? 0 : $urandom_range(0, 10);
            end else if (!s_tvalid && src_gap > 0) begin
                src_gap <= src_gap - 1;
            end else if (!s_tvalid && pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                s_tdata <= {r.wheel_speed, r.wheel_angle, r.elapsed_us,
                            r.gyro_y, r.accel_z, r.accel_x};
                s_tuser <= r.sample_valid;
                nv = 1'b1;
            end
            s_tvalid <= nv;
        end
    end

    // ---------------- result monitor ----------------
    int sink_stall;
    always @(posedge aclk) begin
        control_out_t got;
        control_out_t exp_o;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            sink_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.drive       = m_tdata[31:0];
                got.pitch_angle = m_tdata[52:32];
                got.pitch_rate  = m_tdata[73:53];
                got.accel_angle = m_tdata[93:74];
                if (expected_outs.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_tdata);
                    error_count++;
                end else begin
                    exp_o = expected_outs.pop_front();
                    checked_count++;
                    if (got.drive !== exp_o.drive) begin
                        $display("%0t: drive exp %0d got %0d", $time, exp_o.drive, got.drive);
                        error_count++;
                    end
                    if (got.pitch_angle !== exp_o.pitch_angle) begin
                        $display("%0t: pitch_angle exp %0d got %0d", $time,
                                 exp_o.pitch_angle, got.pitch_angle);
                        error_count++;
                    end
                    if (got.pitch_rate !== exp_o.pitch_rate) begin
                        $display("%0t: pitch_rate exp %0d got %0d", $time,
                                 exp_o.pitch_rate, got.pitch_rate);
                        error_count++;
                    end
                    if (got.accel_angle !== exp_o.accel_angle) begin
                        $display("%0t: accel_angle exp %0d got %0d", $time,
                                 exp_o.accel_angle, got.accel_angle);
                        error_count++;
                    end
                end
                sink_stall <= sink_quiet ? 0 : $urandom_range(0, 10);
                m_tready   <= sink_quiet;
            end else if (sink_stall > 0) begin
                sink_stall <= sink_stall - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        apply_reg(idx, v);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all(logic [31:0] gp, logic [31:0] gr, logic [31:0] gwa,
                             logic [31:0] gws, logic [31:0] al, logic [31:0] tr,
                             logic [31:0] off, logic [31:0] lim);
        write_reg(REG_GAIN_PITCH, gp);
        write_reg(REG_GAIN_RATE, gr);
        write_reg(REG_GAIN_WANGLE, gwa);
        write_reg(REG_GAIN_WSPEED, gws);
        write_reg(REG_ALPHA, al);
        write_reg(REG_TRUST, tr);
        write_reg(REG_OFFSET, off);
        write_reg(REG_LIMIT, lim);
    endtask

    // sender holds off until the block has drained; then a latency margin
    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_outs.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic void add_req(int ax, int az, int gy, bit v, int el,
                                    int wa, int ws);
        sensor_req_t r;
        r.accel_x = 16'(ax); r.accel_z = 16'(az); r.gyro_y = 16'(gy);
        r.sample_valid = v;
        r.elapsed_us = 16'(el); r.wheel_angle = wa; r.wheel_speed = ws;
        pending_reqs.push_back(r);
    endfunction

    // mostly moderate values, sometimes the full 32-bit span
    function automatic logic [31:0] rnd_wide(int small_span);
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $signed($urandom_range(0, 2 * small_span)) - small_span;
    endfunction

    function automatic void add_random(int n);
        int ax;
        int az;
        int el;
        for (int i = 0; i < n; i++) begin
            // mostly a plausible gravity vector, sometimes raw noise
            if ($urandom_range(0, 2) == 0) begin
                ax = $signed(16'($urandom)); az = $signed(16'($urandom));
            end else begin
                ax = $urandom_range(0, 8000) - 4000;
                az = $urandom_range(0, 4000) - 18000;
            end
            el = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(4000, 6000);
            add_req(ax, az, $signed(16'($urandom)), $urandom_range(0, 9) != 0, el,
                    rnd_wide(1 << 18), rnd_wide(1 << 20));
        end
    endfunction

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        src_quiet = 1'b0;
        sink_quiet = 1'b0;
        error_count = 0;
        checked_count = 0;
        invalid_count = 0;
        k_pitch = 0; k_rate = 0; k_wangle = 0; k_wspeed = 0;
        alpha_reg = 64225; trust_reg = 65536; offset_reg = 0; limit_reg = 655360;
        pitch_est = 0; rate_est = 0; tilt_est = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: default registers, field extremes and corner cases
        add_req(0, 0, 0, 1, 0, 0, 0);                         // both accel axes zero
        add_req(0, 16384, 0, 1, 5000, 0, 0);                  // Z up: tilt near -pi
        add_req(0, -16384, 131, 1, 5000, 0, 0);
        add_req(32767, 0, 32767, 1, 65535, 0, 0);
        add_req(-32768, 0, -32768, 1, 65535, 0, 0);
        add_req(-32768, -32768, 0, 1, 1, 0, 0);
        add_req(32767, 32767, -1, 1, 5000, 0, 0);
        add_req(-1, -1, 1, 1, 5000, 0, 0);
        add_req(12345, -22222, 5000, 0, 5000, 0, 0);          // invalid: reuse rate, tilt
        add_req(0, 0, 0, 0, 0, 0, 0);
        drain();
        write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h1FFFF, 32'h1FFFF, 32'h7FFFF, 32'h7FFF_FFFF);
        add_req(32767, -32768, 32767, 1, 65535, 32'h7FFF_FFFF, 32'h8000_0000);
        add_req(-32768, 32767, -32768, 1, 65535, 32'h8000_0000, 32'h7FFF_FFFF);
        add_req(0, 100, 0, 0, 65535, -1, 1);
        add_req(100, 0, 100, 1, 0, 0, 0);
        drain();

        // phase: mild gains, alpha zero, small limit of zero, no idling
        src_quiet = 1'b1; sink_quiet = 1'b1;
        write_all(32'd300000, 32'd20000, -32'sd5000, -32'sd7000,
                  32'd0, 32'd65536, 32'h80000, 32'd0);
        add_random(80);
        drain();
        src_quiet = 1'b0; sink_quiet = 1'b0;

        // phase: typical balancing setup with random idling
        write_all(32'd1500000, 32'd60000, 32'd2000, 32'd9000,
                  32'd64225, 32'd65536, 32'd3000, 32'd655360);
        add_random(140);
        drain();

        // phase: alpha at full gyro weight, trust zero, wide limit
        write_all(rnd_wide(1 << 22), rnd_wide(1 << 22), rnd_wide(1 << 16),
                  rnd_wide(1 << 16), 32'd65536, 32'd0, 32'hFFFF0, 32'h7FFF_FFFF);
        add_random(120);
        drain();

        // phase: random registers, sender bursts against a stalling receiver
        src_quiet = 1'b1;
        write_all(rnd_wide(1 << 21), rnd_wide(1 << 21), rnd_wide(1 << 18),
                  rnd_wide(1 << 18), $urandom_range(0, 131071),
                  $urandom_range(0, 131071), $urandom, $urandom);
        add_random(140);
        drain();

        $display("checked %0d results (%0d invalid samples) over six register settings",
                 checked_count, invalid_count);
        $display("covered: zero/vertical accel, field extremes, alpha/trust saturation, limits");
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
